FILE: rtl/point_to_segment_distance_macros.svh
// Assertion macros for the point-to-segment distance block.
`ifndef POINT_TO_SEGMENT_DISTANCE_MACROS_SVH
`define POINT_TO_SEGMENT_DISTANCE_MACROS_SVH
`ifndef ASSERT_OFF
`define PSD_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("psd assertion failed");
`define PSD_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("psd assertion failed");
`else
`define PSD_ASSERT(label, prop)
`define PSD_ASSERT_ALWAYS(label, prop)
`endif
`endif

FILE: rtl/psd_pkg.sv
// Shared widths and codes for the point-to-segment distance block.
package psd_pkg;

    localparam int COORD_W  = 20;
    localparam int DIFF_W   = 21;
    localparam int PROD_W   = 42;
    localparam int SUM_W    = 43;
    localparam int HALF_W   = 21;
    localparam int NUM_W    = 83;
    localparam int DEN_W    = 42;
    localparam int QUO_W    = 41;
    localparam int ROOT_W   = 21;
    localparam int RAD_W    = 2 * ROOT_W;
    localparam int SREM_W   = ROOT_W + 2;
    localparam int DIST_W   = 21;
    localparam int REGION_W = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [REGION_W-1:0] REGION_DEGENERATE = 2'd0;
    localparam logic [REGION_W-1:0] REGION_START      = 2'd1;
    localparam logic [REGION_W-1:0] REGION_END        = 2'd2;
    localparam logic [REGION_W-1:0] REGION_INTERIOR   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_START_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_X   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_Y   = 2'd3;

    typedef logic [REGION_W-1:0] region_t;

endpackage

FILE: rtl/point_to_segment_distance.sv
// Point-to-segment distance: top level with front pipeline and output register.
// Stages: 6 front stages, 41 divider stages, 21 square-root stages and
// 1 output register.
// Throughput: one beat per cycle; the whole pipeline advances together and
// holds while the output register is full and not taken.
// Reset: rst_n clears all valid bits and the segment registers to zero.
`include "point_to_segment_distance_macros.svh"
module point_to_segment_distance
    import psd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,   // point_x[19:0], point_y[39:20]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // distance[20:0], zero pad
    output logic [1:0]           m_tuser    // region[1:0]
);

    logic signed [COORD_W-1:0] start_x_reg, start_y_reg, end_x_reg, end_y_reg;
    logic en;

    logic signed [COORD_W-1:0] point_x, point_y;
    assign point_x = s_tdata[COORD_W-1:0];
    assign point_y = s_tdata[2*COORD_W-1:COORD_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            end_x_reg   <= '0;
            end_y_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_START_X: start_x_reg <= cfg_data;
                CFG_START_Y: start_y_reg <= cfg_data;
                CFG_END_X:   end_x_reg   <= cfg_data;
                CFG_END_Y:   end_y_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: differences
    logic s1_valid_reg;
    logic signed [DIFF_W-1:0] abx_reg, aby_reg, apx_reg, apy_reg, bpx_reg, bpy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            abx_reg <= DIFF_W'(end_x_reg) - DIFF_W'(start_x_reg);
            aby_reg <= DIFF_W'(end_y_reg) - DIFF_W'(start_y_reg);
            apx_reg <= DIFF_W'(point_x) - DIFF_W'(start_x_reg);
            apy_reg <= DIFF_W'(point_y) - DIFF_W'(start_y_reg);
            bpx_reg <= DIFF_W'(point_x) - DIFF_W'(end_x_reg);
            bpy_reg <= DIFF_W'(point_y) - DIFF_W'(end_y_reg);
        end
    end

    // stage 2: products
    logic s2_valid_reg, s2_degen_reg;
    logic signed [PROD_W-1:0] p_dx_reg, p_dy_reg, p_abx2_reg, p_aby2_reg;
    logic signed [PROD_W-1:0] p_c1_reg, p_c2_reg;
    logic signed [PROD_W-1:0] p_apx2_reg, p_apy2_reg, p_bpx2_reg, p_bpy2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_degen_reg <= (abx_reg == '0) && (aby_reg == '0);
            p_dx_reg     <= PROD_W'(abx_reg) * PROD_W'(apx_reg);
            p_dy_reg     <= PROD_W'(aby_reg) * PROD_W'(apy_reg);
            p_abx2_reg   <= PROD_W'(abx_reg) * PROD_W'(abx_reg);
            p_aby2_reg   <= PROD_W'(aby_reg) * PROD_W'(aby_reg);
            p_c1_reg     <= PROD_W'(abx_reg) * PROD_W'(apy_reg);
            p_c2_reg     <= PROD_W'(aby_reg) * PROD_W'(apx_reg);
            p_apx2_reg   <= PROD_W'(apx_reg) * PROD_W'(apx_reg);
            p_apy2_reg   <= PROD_W'(apy_reg) * PROD_W'(apy_reg);
            p_bpx2_reg   <= PROD_W'(bpx_reg) * PROD_W'(bpx_reg);
            p_bpy2_reg   <= PROD_W'(bpy_reg) * PROD_W'(bpy_reg);
        end
    end

    // stage 3: sums
    logic s3_valid_reg, s3_degen_reg;
    logic signed [SUM_W-1:0] dot_reg, cross_reg;
    logic [SUM_W-1:0] ab2_sum, ap2_sum, bp2_sum;
    logic [DEN_W-1:0] ab2_reg, ap2_reg, bp2_reg;

    assign ab2_sum = SUM_W'(p_abx2_reg) + SUM_W'(p_aby2_reg);
    assign ap2_sum = SUM_W'(p_apx2_reg) + SUM_W'(p_apy2_reg);
    assign bp2_sum = SUM_W'(p_bpx2_reg) + SUM_W'(p_bpy2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_degen_reg <= s2_degen_reg;
            dot_reg      <= SUM_W'(p_dx_reg) + SUM_W'(p_dy_reg);
            cross_reg    <= SUM_W'(p_c1_reg) - SUM_W'(p_c2_reg);
            ab2_reg      <= ab2_sum[DEN_W-1:0];
            ap2_reg      <= ap2_sum[DEN_W-1:0];
            bp2_reg      <= bp2_sum[DEN_W-1:0];
        end
    end

    // stage 4: region decision
    logic s4_valid_reg;
    region_t s4_region_reg, region_next;
    logic [DEN_W-1:0] s4_den_reg, s4_sq_reg;
    logic [SUM_W-1:0] cabs;
    logic [HALF_W-1:0] ch_reg, cl_reg;

    always_comb
    begin
        if (s3_degen_reg)
        begin
            region_next = REGION_DEGENERATE;
        end
        else if (dot_reg < 0)
        begin
            region_next = REGION_START;
        end
        else if (dot_reg > $signed({1'b0, ab2_reg}))
        begin
            region_next = REGION_END;
        end
        else
        begin
            region_next = REGION_INTERIOR;
        end
    end

    assign cabs = cross_reg[SUM_W-1] ? (SUM_W'(0) - cross_reg) : cross_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_region_reg <= region_next;
            s4_den_reg    <= (region_next == REGION_INTERIOR) ? ab2_reg : DEN_W'(1);
            s4_sq_reg     <= (region_next == REGION_END) ? bp2_reg : ap2_reg;
            ch_reg        <= cabs[2*HALF_W-1:HALF_W];
            cl_reg        <= cabs[HALF_W-1:0];
        end
    end

    // stage 5: partial products of cross^2
    logic s5_valid_reg;
    region_t s5_region_reg;
    logic [DEN_W-1:0] s5_den_reg, s5_sq_reg;
    logic [2*HALF_W-1:0] pll_reg, plh_reg, phh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_region_reg <= s4_region_reg;
            s5_den_reg    <= s4_den_reg;
            s5_sq_reg     <= s4_sq_reg;
            pll_reg       <= (2*HALF_W)'(cl_reg) * (2*HALF_W)'(cl_reg);
            plh_reg       <= (2*HALF_W)'(ch_reg) * (2*HALF_W)'(cl_reg);
            phh_reg       <= (2*HALF_W)'(ch_reg) * (2*HALF_W)'(ch_reg);
        end
    end

    // stage 6: dividend assembly
    logic s6_valid_reg;
    region_t s6_region_reg;
    logic [DEN_W-1:0] s6_den_reg;
    logic [NUM_W-1:0] s6_num_reg;
    logic [NUM_W:0] csq;

    assign csq = ((NUM_W+1)'(phh_reg) << (2*HALF_W))
               + ((NUM_W+1)'(plh_reg) << (HALF_W+1))
               + (NUM_W+1)'(pll_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_region_reg <= s5_region_reg;
            s6_den_reg    <= s5_den_reg;
            s6_num_reg    <= (s5_region_reg == REGION_INTERIOR) ? csq[NUM_W-1:0]
                                                               : NUM_W'(s5_sq_reg);
        end
    end

    // squared distance, then root
    logic div_valid, root_valid;
    logic [QUO_W-1:0] div_quo;
    logic [ROOT_W-1:0] root;
    region_t div_tag, root_tag;

    psd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s6_valid_reg),
        .in_num    (s6_num_reg),
        .in_den    (s6_den_reg),
        .in_tag    (s6_region_reg),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_tag   (div_tag)
    );

    psd_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .in_rad    (div_quo),
        .in_tag    (div_tag),
        .out_valid (root_valid),
        .out_root  (root),
        .out_tag   (root_tag)
    );

    // output register
    logic out_valid_reg;
    logic [DIST_W-1:0] out_dist_reg;
    region_t out_region_reg;

    assign en = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= root_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_dist_reg   <= root;
            out_region_reg <= root_tag;
        end
    end

    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_dist_reg};
    assign m_tuser  = out_region_reg;

    `PSD_ASSERT(a_interior_den, s4_valid_reg && s4_region_reg == REGION_INTERIOR |-> s4_den_reg != '0)
    `PSD_ASSERT(a_edge_den_one, s4_valid_reg && s4_region_reg != REGION_INTERIOR |-> s4_den_reg == DEN_W'(1))
    `PSD_ASSERT(a_stall_holds, !en |=> $stable(s1_valid_reg) && $stable(s6_valid_reg))
    `PSD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_reg)

endmodule

FILE: rtl/psd_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module psd_div
    import psd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0] in_den,
    input  region_t          in_tag,
    output logic             out_valid,
    output logic [QUO_W-1:0] out_quo,
    output region_t          out_tag
);

    logic             v_reg   [QUO_W];
    logic [DEN_W-1:0] rem_reg [QUO_W];
    logic [QUO_W-1:0] lo_reg  [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];
    region_t          tag_reg [QUO_W];

    for (genvar i = 0; i < QUO_W; i++) begin : g_stage
        logic             sv;
        logic [DEN_W-1:0] srem;
        logic [QUO_W-1:0] slo;
        logic [DEN_W-1:0] sden;
        logic [QUO_W-1:0] squo;
        region_t          stag;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;
        logic [DEN_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;

        if (i == 0) begin : g_first
            assign sv   = in_valid;
            assign srem = in_num[NUM_W-1:QUO_W];
            assign slo  = in_num[QUO_W-1:0];
            assign sden = in_den;
            assign squo = '0;
            assign stag = in_tag;
        end
        else begin : g_next
            assign sv   = v_reg[i-1];
            assign srem = rem_reg[i-1];
            assign slo  = lo_reg[i-1];
            assign sden = den_reg[i-1];
            assign squo = quo_reg[i-1];
            assign stag = tag_reg[i-1];
        end

        assign trial    = {srem, slo[QUO_W-1]};
        assign diff     = trial - {1'b0, sden};
        assign ge       = trial >= {1'b0, sden};
        assign rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        assign quo_next = {squo[QUO_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= sv;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next;
                lo_reg[i]  <= {slo[QUO_W-2:0], 1'b0};
                den_reg[i] <= sden;
                quo_reg[i] <= quo_next;
                tag_reg[i] <= stag;
            end
        end
    end

    assign out_valid = v_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];
    assign out_tag   = tag_reg[QUO_W-1];

endmodule

FILE: rtl/psd_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module psd_sqrt
    import psd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [QUO_W-1:0]  in_rad,
    input  region_t           in_tag,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output region_t           out_tag
);

    logic              v_reg    [ROOT_W];
    logic [SREM_W-1:0] rem_reg  [ROOT_W];
    logic [RAD_W-1:0]  x_reg    [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    region_t           tag_reg  [ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
        logic              sv;
        logic [SREM_W-1:0] srem;
        logic [RAD_W-1:0]  sx;
        logic [ROOT_W-1:0] sroot;
        region_t           stag;
        logic [SREM_W+1:0] trial;
        logic [SREM_W+1:0] sub;
        logic [SREM_W+1:0] diff;
        logic              ge;

        if (i == 0) begin : g_first
            assign sv    = in_valid;
            assign srem  = '0;
            assign sx    = {{(RAD_W-QUO_W){1'b0}}, in_rad};
            assign sroot = '0;
            assign stag  = in_tag;
        end
        else begin : g_next
            assign sv    = v_reg[i-1];
            assign srem  = rem_reg[i-1];
            assign sx    = x_reg[i-1];
            assign sroot = root_reg[i-1];
            assign stag  = tag_reg[i-1];
        end

        assign trial = {srem, sx[RAD_W-1:RAD_W-2]};
        assign sub   = {2'b00, sroot, 2'b01};
        assign ge    = trial >= sub;
        assign diff  = trial - sub;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= sv;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= ge ? diff[SREM_W-1:0] : trial[SREM_W-1:0];
                x_reg[i]    <= {sx[RAD_W-3:0], 2'b00};
                root_reg[i] <= {sroot[ROOT_W-2:0], ge};
                tag_reg[i]  <= stag;
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_tag   = tag_reg[ROOT_W-1];

endmodule
